// File: src/route_table_binary_search_lookup_assert.svh
// assertion macros for the route table lookup
// each check samples on the rising edge of clk and is held off while rst_n is low
`ifndef ROUTE_TABLE_BINARY_SEARCH_LOOKUP_ASSERT_SVH
`define ROUTE_TABLE_BINARY_SEARCH_LOOKUP_ASSERT_SVH

`ifndef SYNTHESIS

// implication checked every cycle out of reset
`define RTBS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same check with the previous cycle also required out of reset
`define RTBS_ASSERT_PAST(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) $past(rst_n) |-> prop) \
        else $error(msg);

`else

`define RTBS_ASSERT(label, prop, msg)
`define RTBS_ASSERT_PAST(label, prop, msg)

`endif

`endif

// File: src/rtbs_pkg.sv
`default_nettype none

package rtbs_pkg;

    // fixed field widths
    localparam int DATA_W = 32;
    localparam int PORT_W = 4;
    localparam int IDX_W  = 10;
    localparam int CNT_W  = 11;

    // item kinds
    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    // search sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } state_t;

    // outcome of one probe
    typedef struct packed {
        logic hit;
        logic go_right;
    } probe_res_t;

endpackage

`default_nettype wire

// File: src/rtbs_store.sv
`default_nettype none

module rtbs_store
    import rtbs_pkg::*;
#(
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [DATA_W-1:0] wr_prefix,
    input  wire logic [DATA_W-1:0] wr_mask,
    input  wire logic [DATA_W-1:0] wr_hop,
    input  wire logic [PORT_W-1:0] wr_port,
    input  wire logic [AW-1:0]     rd_addr,
    output logic      [DATA_W-1:0] rd_prefix,
    output logic      [DATA_W-1:0] rd_prev_prefix,
    output logic      [DATA_W-1:0] rd_mask,
    output logic      [DATA_W-1:0] rd_hop,
    output logic      [PORT_W-1:0] rd_port
);

    logic [DATA_W-1:0] prefix_mem [DEPTH];
    logic [DATA_W-1:0] mask_mem   [DEPTH];
    logic [DATA_W-1:0] hop_mem    [DEPTH];
    logic [PORT_W-1:0] port_mem   [DEPTH];

    logic [AW-1:0] prev_addr;

    // previous entry for the lower-bound check, wraps at index zero
    assign prev_addr = rd_addr - AW'(1);

    // single write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            prefix_mem[wr_addr] <= wr_prefix;
            mask_mem[wr_addr]   <= wr_mask;
            hop_mem[wr_addr]    <= wr_hop;
            port_mem[wr_addr]   <= wr_port;
        end
    end

    // registered reads, prefix read at two addresses
    always_ff @(posedge clk)
    begin
        rd_prefix      <= prefix_mem[rd_addr];
        rd_prev_prefix <= prefix_mem[prev_addr];
        rd_mask        <= mask_mem[rd_addr];
        rd_hop         <= hop_mem[rd_addr];
        rd_port        <= port_mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: src/rtbs_probe.sv
`default_nettype none

module rtbs_probe
    import rtbs_pkg::*;
(
    input  wire logic [DATA_W-1:0] dest,
    input  wire logic [DATA_W-1:0] mask,
    input  wire logic [DATA_W-1:0] prefix,
    input  wire logic [DATA_W-1:0] prev_prefix,
    input  wire logic              mid_zero,
    output probe_res_t             res
);

    logic [DATA_W-1:0] masked;

    // masked destination against the entry and its predecessor
    assign masked       = dest & mask;
    assign res.hit      = (masked == prefix) && (mid_zero || (masked > prev_prefix));
    assign res.go_right = masked > prefix;

endmodule

`default_nettype wire

// File: src/route_table_binary_search_lookup.sv
// channel  | handshake            | word
// ---------+----------------------+------------------------------------------------
// in       | in_valid / in_stall  | mode, entry_index, entry_prefix, entry_mask,
//          |                      | entry_next_hop, entry_port, dest_addr
// out      | out_valid / out_stall| found, hop_addr, out_port, matched_index
// cfg      | cfg_wr_en            | cfg_wr_data (entry_count)
//
// a write word is taken while idle and gives no result
// a lookup takes at most ceil(log2(count + 1)) probes, 11 for 1024 entries:
// each probe waits on the registered table read before its compare picks the
// next middle index
// reset clears the sequencer, output valid and entry_count; table contents are
// undefined until written and get no clearing pass
// in_stall is high from the accepted lookup until its result is in the output
// register, and out_stall holds a waiting result without losing it
`default_nettype none

`include "route_table_binary_search_lookup_assert.svh"

module route_table_binary_search_lookup
    import rtbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              cfg_wr_en,
    input  wire logic [CNT_W-1:0]  cfg_wr_data,

    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              mode,
    input  wire logic [IDX_W-1:0]  entry_index,
    input  wire logic [DATA_W-1:0] entry_prefix,
    input  wire logic [DATA_W-1:0] entry_mask,
    input  wire logic [DATA_W-1:0] entry_next_hop,
    input  wire logic [PORT_W-1:0] entry_port,
    input  wire logic [DATA_W-1:0] dest_addr,

    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   found,
    output logic      [DATA_W-1:0] hop_addr,
    output logic      [PORT_W-1:0] out_port,
    output logic      [IDX_W-1:0]  matched_index
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  entry_count_reg;
    logic [CW-1:0]     active_cnt;
    logic [CW-1:0]     lo_reg, lo_next;
    logic [CW-1:0]     end_reg, end_next;
    logic [CW-1:0]     span;
    logic [CW-1:0]     mid_full;
    logic [AW-1:0]     mid;
    logic [31:0]       mid_wide;
    logic [31:0]       wr_idx_wide;
    logic [DATA_W-1:0] dest_reg, dest_next;

    logic              res_found_reg, res_found_next;
    logic [DATA_W-1:0] res_hop_reg, res_hop_next;
    logic [PORT_W-1:0] res_port_reg, res_port_next;
    logic [IDX_W-1:0]  res_index_reg, res_index_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_found_reg, out_found_next;
    logic [DATA_W-1:0] out_hop_reg, out_hop_next;
    logic [PORT_W-1:0] out_port_reg, out_port_next;
    logic [IDX_W-1:0]  out_index_reg, out_index_next;

    logic              in_take;
    logic              out_free;
    logic              tbl_wr_en;

    logic [DATA_W-1:0] rd_prefix;
    logic [DATA_W-1:0] rd_prev_prefix;
    logic [DATA_W-1:0] rd_mask;
    logic [DATA_W-1:0] rd_hop;
    logic [PORT_W-1:0] rd_port;
    probe_res_t        probe;

    // handshake
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign found         = out_found_reg;
    assign hop_addr      = out_hop_reg;
    assign out_port      = out_port_reg;
    assign matched_index = out_index_reg;

    // entries in use, saturated to the table
    assign active_cnt = (32'(entry_count_reg) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                                  : CW'(entry_count_reg);

    // middle of [lo, end)
    assign span     = end_reg - lo_reg;
    assign mid_full = lo_reg + ((span - CW'(1)) >> 1);
    assign mid      = mid_full[AW-1:0];
    assign mid_wide = 32'(mid);

    // table write, out-of-range indexes dropped
    assign wr_idx_wide = 32'(entry_index);
    assign tbl_wr_en   = in_take && (mode == MODE_WRITE) && (wr_idx_wide < 32'(TABLE_DEPTH));

    rtbs_store #(
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .clk            (clk),
        .wr_en          (tbl_wr_en),
        .wr_addr        (wr_idx_wide[AW-1:0]),
        .wr_prefix      (entry_prefix),
        .wr_mask        (entry_mask),
        .wr_hop         (entry_next_hop),
        .wr_port        (entry_port),
        .rd_addr        (mid),
        .rd_prefix      (rd_prefix),
        .rd_prev_prefix (rd_prev_prefix),
        .rd_mask        (rd_mask),
        .rd_hop         (rd_hop),
        .rd_port        (rd_port)
    );

    rtbs_probe u_probe (
        .dest        (dest_reg),
        .mask        (rd_mask),
        .prefix      (rd_prefix),
        .prev_prefix (rd_prev_prefix),
        .mid_zero    (mid == '0),
        .res         (probe)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take && (mode == MODE_LOOKUP))
                begin
                    state_next = (active_cnt == '0) ? ST_DONE : ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (probe.hit)
                begin
                    state_next = ST_DONE;
                end
                else if (probe.go_right)
                begin
                    state_next = (mid_full + CW'(1) >= end_reg) ? ST_DONE : ST_READ;
                end
                else
                begin
                    state_next = (lo_reg >= mid_full) ? ST_DONE : ST_READ;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // search range, result and output register updates
    always_comb
    begin
        lo_next        = lo_reg;
        end_next       = end_reg;
        dest_next      = dest_reg;
        res_found_next = res_found_reg;
        res_hop_next   = res_hop_reg;
        res_port_next  = res_port_reg;
        res_index_next = res_index_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_found_next = out_found_reg;
        out_hop_next   = out_hop_reg;
        out_port_next  = out_port_reg;
        out_index_next = out_index_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                lo_next        = '0;
                end_next       = active_cnt;
                dest_next      = dest_addr;
                res_found_next = 1'b0;
                res_hop_next   = '0;
                res_port_next  = '0;
                res_index_next = '0;
            end
            ST_READ:
            begin
            end
            ST_CHECK:
            begin
                if (probe.hit)
                begin
                    res_found_next = 1'b1;
                    res_hop_next   = rd_hop;
                    res_port_next  = rd_port;
                    res_index_next = mid_wide[IDX_W-1:0];
                end
                else if (probe.go_right)
                begin
                    lo_next = mid_full + CW'(1);
                end
                else
                begin
                    end_next = mid_full;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = res_found_reg;
                    out_hop_next   = res_hop_reg;
                    out_port_next  = res_port_reg;
                    out_index_next = res_index_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            entry_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                entry_count_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        end_reg       <= end_next;
        dest_reg      <= dest_next;
        res_found_reg <= res_found_next;
        res_hop_reg   <= res_hop_next;
        res_port_reg  <= res_port_next;
        res_index_reg <= res_index_next;
        out_found_reg <= out_found_next;
        out_hop_reg   <= out_hop_next;
        out_port_reg  <= out_port_next;
        out_index_reg <= out_index_next;
    end

    // checks
    `RTBS_ASSERT_PAST(a_check_after_read, (state_reg == ST_CHECK) |-> ($past(state_reg) == ST_READ), "probe compare without a table read")
    `RTBS_ASSERT(a_read_range_open, (state_reg == ST_READ) |-> (lo_reg < end_reg), "table read with an empty search range")
    `RTBS_ASSERT(a_hit_in_range, (out_valid && found) |-> (32'(matched_index) < 32'(active_cnt)), "match outside the entries in use")
    `RTBS_ASSERT(a_miss_zeroed, (out_valid && !found) |-> ((hop_addr == '0) && (out_port == '0) && (matched_index == '0)), "miss word carries nonzero fields")

endmodule

`default_nettype wire
